FILE: sv/bprq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprq_pkg: shared constants for the bitmap priority runqueue
// Opcodes, status codes, level constants and default sizes.
// ----------------------------------------------------------------------------
package bprq_pkg;
    localparam int NUM_CPUS_DEF    = 4;
    localparam int PRIO_LEVELS_DEF = 140;
    localparam int POOL_SLOTS_DEF  = 64;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_RETURN  = 2'd1;
    localparam logic [1:0] OP_REQUEST = 2'd2;

    localparam logic [1:0] ST_QUEUED   = 2'd0;
    localparam logic [1:0] ST_DISPATCH = 2'd1;
    localparam logic [1:0] ST_NONE     = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [7:0] NORMAL_BASE = 8'd120;
    localparam logic [6:0] RT_MAX      = 7'd99;
endpackage

FILE: sv/bitmap_priority_runqueue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_priority_runqueue: per-CPU O(1) scheduler runqueues
// Active/expired arrays of FIFO levels with occupancy bitmaps, shared pool.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | word
//  in      | input     | i_valid / o_stall      | opcode, cpu, task, level info
//  out     | output    | o_valid / i_stall      | status, task id, level
//
//  An insert or return scans the free mask (16 slots per cycle), waits for the
//  registered tail read, then links the slot and answers. A request scans the
//  bitmap (16 levels per cycle), makes a second full scan after a swap if the
//  first finds nothing, then does head read, link/task read and pop.
//  A reserved opcode answers with status none, with no scan or memory access.
//  Reset clears bitmaps and array select and marks every pool slot free at once; no pass.
//  The result waits in an output register while i_stall is high; no new
//  word is taken until it has been delivered.
// ----------------------------------------------------------------------------
module bitmap_priority_runqueue #(
    parameter int NUM_CPUS    = bprq_pkg::NUM_CPUS_DEF,
    parameter int PRIO_LEVELS = bprq_pkg::PRIO_LEVELS_DEF,
    parameter int POOL_SLOTS  = bprq_pkg::POOL_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_opcode,
    input  logic [1:0]        i_cpu_id,
    input  logic [15:0]       i_task_id,
    input  logic              i_policy,
    input  logic [6:0]        i_rt_level,
    input  logic signed [5:0] i_nice_value,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_status,
    output logic [15:0]       o_out_task_id,
    output logic [7:0]        o_out_level
);
    import bprq_pkg::*;

    localparam int NARR  = NUM_CPUS * 2;
    localparam int AW    = (NARR > 1) ? $clog2(NARR) : 1;
    localparam int CW    = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int SW    = $clog2(POOL_SLOTS);
    localparam int LW    = 8;
    localparam int CHUNK = 16;
    localparam int NCH   = (PRIO_LEVELS + CHUNK - 1) / CHUNK;
    localparam int QW    = $clog2(NCH);
    localparam int PADW  = NCH * CHUNK;
    localparam int HDEP  = NARR * 256;
    localparam int HW    = AW + LW;
    localparam int FCH   = 16;
    localparam int NFC   = (POOL_SLOTS + FCH - 1) / FCH;
    localparam int FQW   = (NFC > 1) ? $clog2(NFC) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FREE  = 4'd1;
    localparam logic [3:0] S_ENQ   = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_HRD   = 4'd4;
    localparam logic [3:0] S_HWAIT = 4'd5;
    localparam logic [3:0] S_POP   = 4'd6;
    localparam logic [3:0] S_TWAIT = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]            r_state;
    logic [PRIO_LEVELS-1:0] r_bitmap [NARR];
    logic [NUM_CPUS-1:0]   r_sel;
    logic [POOL_SLOTS-1:0] r_free;
    logic [1:0]            r_op;
    logic [CW-1:0]         r_cpu;
    logic [15:0]           r_task;
    logic [LW-1:0]         r_lvl;
    logic [AW-1:0]         r_arr;
    logic [QW-1:0]         r_q;
    logic [FQW-1:0]        r_fq;
    logic                  r_retry;
    logic [SW-1:0]         r_slot;
    logic                  r_ovalid;
    logic [1:0]            r_ostat;
    logic [15:0]           r_otask;
    logic [7:0]            r_olvl;

    // memories: head, tail, link, task
    logic          w_h_we, w_t_we, w_n_we, w_k_we;
    logic [HW-1:0] w_h_wa, w_t_wa, w_h_ra;
    logic [SW-1:0] w_h_wd, w_t_wd, w_n_wa, w_n_wd, w_n_ra, w_k_wa, w_k_ra;
    logic [SW-1:0] w_h_rd, w_t_rd, w_n_rd;
    logic [15:0]   w_k_rd;

    bprq_ram #(.WIDTH(SW), .DEPTH(HDEP)) u_head (
        .i_clk(i_clk), .i_we(w_h_we), .i_waddr(w_h_wa), .i_wdata(w_h_wd),
        .i_raddr(w_h_ra), .o_rdata(w_h_rd));
    bprq_ram #(.WIDTH(SW), .DEPTH(HDEP)) u_tail (
        .i_clk(i_clk), .i_we(w_t_we), .i_waddr(w_t_wa), .i_wdata(w_t_wd),
        .i_raddr(w_h_ra), .o_rdata(w_t_rd));
    bprq_ram #(.WIDTH(SW), .DEPTH(POOL_SLOTS)) u_next (
        .i_clk(i_clk), .i_we(w_n_we), .i_waddr(w_n_wa), .i_wdata(w_n_wd),
        .i_raddr(w_n_ra), .o_rdata(w_n_rd));
    bprq_ram #(.WIDTH(16), .DEPTH(POOL_SLOTS)) u_task (
        .i_clk(i_clk), .i_we(w_k_we), .i_waddr(w_k_wa), .i_wdata(r_task),
        .i_raddr(w_k_ra), .o_rdata(w_k_rd));

    // level from policy with saturation
    logic [LW-1:0] w_in_lvl;
    logic [CW-1:0] w_in_cpu;
    always_comb begin
        if (i_policy) begin
            w_in_lvl = (i_rt_level > RT_MAX) ? {1'b0, RT_MAX} : {1'b0, i_rt_level};
        end else if (i_nice_value < -6'sd20) begin
            w_in_lvl = NORMAL_BASE - 8'd20;
        end else if (i_nice_value > 6'sd19) begin
            w_in_lvl = NORMAL_BASE + 8'd19;
        end else begin
            w_in_lvl = NORMAL_BASE + {{2{i_nice_value[5]}}, i_nice_value};
        end
        // fold the CPU index into range
        case (i_cpu_id)
            2'd0: begin
                w_in_cpu = CW'(0 % NUM_CPUS);
            end
            2'd1: begin
                w_in_cpu = CW'(1 % NUM_CPUS);
            end
            2'd2: begin
                w_in_cpu = CW'(2 % NUM_CPUS);
            end
            default: begin
                w_in_cpu = CW'(3 % NUM_CPUS);
            end
        endcase
    end

    // shared scan unit: one 16-bit chunk of bitmap or free mask
    logic [PADW-1:0]     w_bm_pad;
    logic [CHUNK-1:0]    w_bm_chunk;
    logic [NFC*FCH-1:0]  w_fr_pad;
    logic [FCH-1:0]      w_fr_chunk;
    logic [CHUNK-1:0]    w_chunk;
    logic                w_hit;
    logic [3:0]          w_pos;
    always_comb begin
        w_bm_pad   = PADW'(r_bitmap[r_arr]);
        w_bm_chunk = w_bm_pad[r_q*CHUNK +: CHUNK];
        w_fr_pad   = (NFC*FCH)'(r_free);
        w_fr_chunk = w_fr_pad[r_fq*FCH +: FCH];
        w_chunk    = (r_state == S_FREE) ? w_fr_chunk : w_bm_chunk;
        w_hit = 1'b0;
        w_pos = 4'd0;
        for (int i = CHUNK - 1; i >= 0; i--) begin
            if (w_chunk[i]) begin
                w_hit = 1'b1;
                w_pos = 4'(i);
            end
        end
    end

    logic [HW-1:0]  w_haddr;
    logic [31:0]    w_fslot;
    logic           w_set;
    assign w_haddr = {r_arr, r_lvl};
    assign w_fslot = 32'(r_fq) * FCH + 32'(w_pos);
    assign w_set   = r_bitmap[r_arr][r_lvl];

    // memory control
    always_comb begin
        w_h_we = 1'b0; w_t_we = 1'b0; w_n_we = 1'b0; w_k_we = 1'b0;
        w_h_wa = w_haddr; w_t_wa = w_haddr; w_h_ra = w_haddr;
        w_h_wd = r_slot; w_t_wd = r_slot;
        w_n_wa = w_t_rd; w_n_wd = r_slot; w_n_ra = w_h_rd;
        w_k_wa = r_slot; w_k_ra = w_h_rd;
        if (r_state == S_ENQ) begin
            w_k_we = 1'b1;
            w_t_we = 1'b1;
            w_h_we = !w_set;
            w_n_we = w_set;
        end else if (r_state == S_POP) begin
            w_h_we = (w_h_rd != w_t_rd);
            w_h_wd = w_n_rd;
        end
    end

    assign o_stall       = (r_state != S_IDLE) || r_ovalid;
    assign o_valid       = r_ovalid;
    assign o_status      = r_ostat;
    assign o_out_task_id = r_otask;
    assign o_out_level   = r_olvl;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sel    <= '0;
            r_free   <= '1;
            r_ovalid <= 1'b0;
            for (int a = 0; a < NARR; a++) begin
                r_bitmap[a] <= '0;
            end
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_op    <= i_opcode;
                        r_cpu   <= w_in_cpu;
                        r_task  <= i_task_id;
                        r_lvl   <= w_in_lvl;
                        r_q     <= '0;
                        r_fq    <= '0;
                        r_retry <= 1'b0;
                        r_arr   <= AW'({w_in_cpu, 1'b0}) |
                                   AW'(r_sel[w_in_cpu] ^ (i_opcode == OP_RETURN));
                        r_ostat <= ST_NONE;
                        r_otask <= '0;
                        r_olvl  <= '0;
                        if (i_opcode == OP_INSERT || i_opcode == OP_RETURN) begin
                            r_state <= S_FREE;
                        end else if (i_opcode == OP_REQUEST) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_FREE: begin
                    if (w_hit && w_fslot < POOL_SLOTS) begin
                        r_slot  <= SW'(w_fslot);
                        r_state <= S_HRD;
                    end else if (32'(r_fq) == NFC - 1) begin
                        r_ostat <= ST_FULL;
                        r_state <= S_OUT;
                    end else begin
                        r_fq <= r_fq + 1'b1;
                    end
                end
                S_SCAN: begin
                    if (w_hit) begin
                        r_lvl   <= LW'(32'(r_q) * CHUNK + 32'(w_pos));
                        r_state <= S_HRD;
                    end else if (32'(r_q) != NCH - 1) begin
                        r_q <= r_q + 1'b1;
                    end else if (!r_retry) begin
                        r_sel[r_cpu] <= ~r_sel[r_cpu];
                        r_arr[0]     <= ~r_arr[0];
                        r_retry      <= 1'b1;
                        r_q          <= '0;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_HRD: begin
                    r_state <= (r_op == OP_REQUEST) ? S_HWAIT : S_TWAIT;
                end
                S_TWAIT: begin
                    r_state <= S_ENQ;
                end
                S_ENQ: begin
                    r_free[r_slot]       <= 1'b0;
                    r_bitmap[r_arr][r_lvl] <= 1'b1;
                    r_ostat <= ST_QUEUED;
                    r_state <= S_OUT;
                end
                S_HWAIT: begin
                    r_state <= S_POP;
                end
                S_POP: begin
                    if (w_h_rd == w_t_rd) begin
                        r_bitmap[r_arr][r_lvl] <= 1'b0;
                    end
                    r_free[w_h_rd] <= 1'b1;
                    r_ostat <= ST_DISPATCH;
                    r_otask <= w_k_rd;
                    r_olvl  <= r_lvl;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

FILE: sv/bprq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprq_ram: generic simple dual-port RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module bprq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and register read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: verif/bprq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprq_checker: scoreboard for the bitmap priority runqueue
// Watches both channels, models the runqueues and the slot pool, and compares
// each result word with the oldest predicted word.
// ----------------------------------------------------------------------------
module bprq_checker #(
    parameter int NCPU  = bprq_pkg::NUM_CPUS_DEF,
    parameter int NLVL  = bprq_pkg::PRIO_LEVELS_DEF,
    parameter int NSLOT = bprq_pkg::POOL_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_in_stall,
    input  logic [1:0]        i_opcode,
    input  logic [1:0]        i_cpu_id,
    input  logic [15:0]       i_task_id,
    input  logic              i_policy,
    input  logic [6:0]        i_rt_level,
    input  logic signed [5:0] i_nice_value,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [1:0]        i_status,
    input  logic [15:0]       i_out_task_id,
    input  logic [7:0]        i_out_level,
    output int                o_errors,
    output int                o_pending
);
    import bprq_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] task_id;
        logic [7:0]  level;
    } t_sched_word;

    // model state: per array, per level FIFO of slot numbers
    int          lvl_fifo[2*NCPU][NLVL][$];
    logic        act_sel[NCPU];
    logic [15:0] slot_task[NSLOT];
    logic        slot_used[NSLOT];
    t_sched_word sched_expected[$];

    assign o_pending = sched_expected.size();

    function automatic int level_of(logic pol, logic [6:0] rt, logic signed [5:0] nv);
        int n;
        n = nv;
        if (pol) return (rt > RT_MAX) ? RT_MAX : rt;
        if (n < -20) n = -20;
        if (n > 19) n = 19;
        return NORMAL_BASE + n;
    endfunction

    function automatic int pop_lowest(int arr, output int lvl);
        int s;
        s = -1;
        lvl = 0;
        for (int p = 0; p < NLVL; p++) begin
            if (s < 0 && lvl_fifo[arr][p].size() != 0) begin
                s = lvl_fifo[arr][p].pop_front();
                lvl = p;
            end
        end
        return s;
    endfunction

    function automatic t_sched_word predict_dispatch(logic [1:0] op, logic [1:0] cpu_raw,
            logic [15:0] tid, logic pol, logic [6:0] rt, logic signed [5:0] nv);
        t_sched_word w;
        int cpu, arr, s, lvl;
        w = '{status: ST_NONE, task_id: '0, level: '0};
        cpu = cpu_raw % NCPU;
        if (op == OP_INSERT || op == OP_RETURN) begin
            arr = cpu*2 + ((op == OP_INSERT) ? act_sel[cpu] : !act_sel[cpu]);
            s = -1;
            for (int i = NSLOT-1; i >= 0; i--)
                if (!slot_used[i]) s = i;
            if (s < 0) begin
                w.status = ST_FULL;
            end else begin
                slot_used[s] = 1'b1;
                slot_task[s] = tid;
                lvl = level_of(pol, rt, nv);
                lvl_fifo[arr][lvl] = {lvl_fifo[arr][lvl], s};
                w.status = ST_QUEUED;
            end
        end else if (op == OP_REQUEST) begin
            s = pop_lowest(cpu*2 + act_sel[cpu], lvl);
            if (s < 0) begin
                act_sel[cpu] = !act_sel[cpu];
                s = pop_lowest(cpu*2 + act_sel[cpu], lvl);
            end
            if (s >= 0) begin
                slot_used[s] = 1'b0;
                w = '{status: ST_DISPATCH, task_id: slot_task[s], level: lvl[7:0]};
            end
        end
        return w;
    endfunction

    // predict on input accept, compare on output accept
    always @(posedge i_clk) begin
        t_sched_word want, got;
        if (!i_rst_n) begin
            o_errors <= 0;
            sched_expected.delete();
            for (int c = 0; c < NCPU; c++) act_sel[c] = 1'b0;
            for (int i = 0; i < NSLOT; i++) slot_used[i] = 1'b0;
            for (int a = 0; a < 2*NCPU; a++)
                for (int p = 0; p < NLVL; p++) lvl_fifo[a][p].delete();
        end else begin
            if (i_valid && !i_in_stall)
                sched_expected = {sched_expected,
                    predict_dispatch(i_opcode, i_cpu_id, i_task_id,
                                     i_policy, i_rt_level, i_nice_value)};
            if (i_out_valid && !i_out_stall) begin
                got = '{status: i_status, task_id: i_out_task_id, level: i_out_level};
                if (sched_expected.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected result word st=%0d task=%0d lvl=%0d",
                                 got.status, got.task_id, got.level);
                    o_errors <= o_errors + 1;
                end else begin
                    want = sched_expected.pop_front();
                    if (want != got) begin
                        if (o_errors < 10)
                            $display({"mismatch exp st=%0d task=%0d lvl=%0d ",
                                      "got st=%0d task=%0d lvl=%0d"},
                                     want.status, want.task_id, want.level,
                                     got.status, got.task_id, got.level);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus for the bitmap priority runqueue
// Directed corner words, then random insert/return/request traffic under
// several idle and stall mixes, with one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import bprq_pkg::*;

    logic              clk, rst_n;
    logic              in_valid, in_stall;
    logic [1:0]        opcode, cpu_id;
    logic [15:0]       task_id;
    logic              policy;
    logic [6:0]        rt_level;
    logic signed [5:0] nice_value;
    logic              out_valid, out_stall;
    logic [1:0]        status;
    logic [15:0]       out_task_id;
    logic [7:0]        out_level;
    int                errors, pending;
    int                send_idle_pct, recv_stall_pct, holdoff;

    bitmap_priority_runqueue dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_opcode(opcode), .i_cpu_id(cpu_id), .i_task_id(task_id),
        .i_policy(policy), .i_rt_level(rt_level), .i_nice_value(nice_value),
        .o_valid(out_valid), .i_stall(out_stall), .o_status(status),
        .o_out_task_id(out_task_id), .o_out_level(out_level)
    );

    bprq_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_in_stall(in_stall),
        .i_opcode(opcode), .i_cpu_id(cpu_id), .i_task_id(task_id),
        .i_policy(policy), .i_rt_level(rt_level), .i_nice_value(nice_value),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_status(status),
        .i_out_task_id(out_task_id), .i_out_level(out_level),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    // receiver: random stall, or a long counted hold-off
    initial begin
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (holdoff > 0) begin
                holdoff <= holdoff - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // offer one word and hold it until accepted; drop valid only while idling
    task automatic send_word(logic [1:0] op, logic [1:0] cpu, logic [15:0] tid,
                             logic pol, logic [6:0] rt, logic [5:0] nv);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        cpu_id     <= cpu;
        task_id    <= tid;
        policy     <= pol;
        rt_level   <= rt;
        nice_value <= nv;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // mostly valid traffic; requests balance inserts so the pool cycles
    task automatic send_random();
        int r;
        logic [1:0] op;
        r = $urandom_range(99);
        if (r < 33) op = OP_INSERT;
        else if (r < 55) op = OP_RETURN;
        else if (r < 97) op = OP_REQUEST;
        else op = 2'd3;
        send_word(op, 2'($urandom), 16'($urandom), 1'($urandom),
                  7'(($urandom_range(3) == 0) ? $urandom : $urandom_range(99)),
                  6'(($urandom_range(3) == 0) ? int'($urandom)
                                               : int'($urandom_range(39)) - 20));
    endtask

    initial begin
        int ph;
        rst_n = 1'b0; in_valid = 1'b0; opcode = '0; cpu_id = '0; task_id = '0;
        policy = 1'b0; rt_level = '0; nice_value = '0;
        send_idle_pct = 0; recv_stall_pct = 0; holdoff = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty request, level extremes, saturation, reserved op
        send_word(OP_REQUEST, 2'd0, 16'h0, 1'b0, 7'd0, 6'd0);
        send_word(OP_INSERT, 2'd0, 16'hFFFF, 1'b1, 7'd0, 6'd0);
        send_word(OP_INSERT, 2'd0, 16'h0001, 1'b1, 7'd127, 6'd0);
        send_word(OP_INSERT, 2'd0, 16'h0002, 1'b0, 7'd0, 6'b100000);
        send_word(OP_INSERT, 2'd0, 16'h0003, 1'b0, 7'd0, 6'd31);
        send_word(OP_RETURN, 2'd0, 16'h0004, 1'b0, 7'd0, 6'd0);
        send_word(2'd3, 2'd3, 16'hAAAA, 1'b1, 7'd5, 6'd5);
        repeat (6) send_word(OP_REQUEST, 2'd0, 16'h0, 1'b0, 7'd0, 6'd0);
        send_word(OP_RETURN, 2'd3, 16'h5555, 1'b1, 7'd99, 6'd0);
        send_word(OP_REQUEST, 2'd3, 16'h0, 1'b0, 7'd0, 6'd0);
        send_word(OP_REQUEST, 2'd3, 16'h0, 1'b0, 7'd0, 6'd0);
        // fill the pool, overflow, then drain
        for (int i = 0; i < 66; i++)
            send_word(OP_INSERT, i[1:0], i[15:0], 1'b0, 7'd0,
                      6'(int'($urandom_range(39)) - 20));
        for (int i = 0; i < 70; i++)
            send_word(OP_REQUEST, i[1:0], 16'h0, 1'b0, 7'd0, 6'd0);

        // random phases: none, sender idle, receiver stall, both
        for (ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 48 : (ph == 3) ? 21 : 0;
            recv_stall_pct = (ph == 2) ? 48 : (ph == 3) ? 21 : 0;
            if (ph == 2) holdoff = 300;
            repeat (275) send_random();
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
